FILE: rtl/gzd_pkg.sv
package gzd_pkg;

    // Coding modes held in the configuration register
    localparam logic [1:0] ModeIdentity = 2'd0;
    localparam logic [1:0] ModeGzip     = 2'd1;
    localparam logic [1:0] ModeDeflate  = 2'd2;

    // Result kinds
    localparam logic KindPayload = 1'b0;
    localparam logic KindStatus  = 1'b1;

    // End status codes
    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StBadHdr = 2'd1;
    localparam logic [1:0] StTrunc  = 2'd2;
    localparam logic [1:0] StHcrc   = 2'd3;

    // Trailer check kinds
    localparam logic [1:0] CkNone  = 2'd0;
    localparam logic [1:0] CkCrc32 = 2'd1;
    localparam logic [1:0] CkAdler = 2'd2;

    // Container constants
    localparam logic [31:0] CrcPoly    = 32'hEDB88320;
    localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;
    localparam logic [7:0]  GzMagic0   = 8'h1F;
    localparam logic [7:0]  GzMagic1   = 8'h8B;
    localparam logic [7:0]  GzMethod   = 8'h08;
    localparam logic [7:0]  GzFlgRsvd  = 8'hE0;
    localparam logic [3:0]  GzFixedEnd = 4'd9;
    localparam logic [4:0]  GzMinBytes = 5'd18;
    localparam logic [3:0]  GzTrailer  = 4'd8;
    localparam logic [3:0]  ZlTrailer  = 4'd4;
    localparam logic [3:0]  ZlMethod   = 4'd8;
    localparam logic [3:0]  ZlMaxWin   = 4'd7;

    // Result queue sizing
    localparam int ResMax    = 3;
    localparam int FifoDepth = 4;

    typedef enum logic [14:0] {
        PH_START      = 15'h0001,
        PH_GZ_FIXED   = 15'h0002,
        PH_GZ_XLEN0   = 15'h0004,
        PH_GZ_XLEN1   = 15'h0008,
        PH_GZ_EXTRA   = 15'h0010,
        PH_GZ_NAME    = 15'h0020,
        PH_GZ_COMMENT = 15'h0040,
        PH_GZ_HCRC0   = 15'h0080,
        PH_GZ_HCRC1   = 15'h0100,
        PH_GZ_BODY    = 15'h0200,
        PH_DISCARD    = 15'h0400,
        PH_ZL_SECOND  = 15'h0800,
        PH_ZL_BODY    = 15'h1000,
        PH_RAW        = 15'h2000,
        PH_IDENT      = 15'h4000
    } t_phase;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [1:0]  check_kind;
        logic [31:0] expected_check;
        logic [31:0] expected_size;
        logic        final_result;
    } t_result;

    typedef struct packed {
        logic [1:0]              cnt;
        t_result [ResMax-1:0]    res;
    } t_push;

endpackage

FILE: rtl/gzd_if.sv
interface gzd_in_if;
    import gzd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gzd_out_if;
    import gzd_pkg::*;

    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [1:0]  check_kind;
    logic [31:0] expected_check;
    logic [31:0] expected_size;
    logic        final_result;

    modport source (
        output valid, output result_kind, output payload_byte, output status,
        output check_kind, output expected_check, output expected_size,
        output final_result, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input status,
        input check_kind, input expected_check, input expected_size,
        input final_result, output ready
    );
endinterface

FILE: rtl/gzd_parser.sv
module gzd_parser
    import gzd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_push      o_push
);

    logic [1:0]  r_mode;
    t_phase      r_phase,  n_phase;
    logic [3:0]  r_hidx,   n_hidx;
    logic [7:0]  r_flags,  n_flags;
    logic [15:0] r_xrem,   n_xrem;
    logic [31:0] r_crc,    n_crc;
    logic [7:0]  r_hlow,   n_hlow;
    logic [7:0]  r_held,   n_held;
    logic [7:0]  r_dly [8];
    logic [7:0]  n_dly [8];
    logic [3:0]  r_fill,   n_fill;
    logic [4:0]  r_total,  n_total;
    logic [1:0]  r_err,    n_err;

    t_phase      ph;
    logic        skip;
    logic        bad;
    logic [15:0] xlen;
    logic [3:0]  dep;
    logic [1:0]  res_cnt;
    t_result     res [ResMax];

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

    // Next header phase once the given optional field has been passed.
    function automatic t_phase gz_adv(input logic [1:0] level, input logic [7:0] flags);
        t_phase p;
        if (level < 2'd1 && flags[2]) begin
            p = PH_GZ_XLEN0;
        end else if (level < 2'd2 && flags[3]) begin
            p = PH_GZ_NAME;
        end else if (level < 2'd3 && flags[4]) begin
            p = PH_GZ_COMMENT;
        end else if (flags[1]) begin
            p = PH_GZ_HCRC0;
        end else begin
            p = PH_GZ_BODY;
        end
        return p;
    endfunction

    // Since 32 is one more than 31, summing 5-bit digits preserves the residue.
    function automatic logic div31(input logic [15:0] v);
        logic [6:0] s1;
        logic [5:0] s2;
        logic [5:0] s3;
        s1 = 7'(v[4:0]) + 7'(v[9:5]) + 7'(v[14:10]) + 7'(v[15]);
        s2 = 6'(s1[4:0]) + 6'(s1[6:5]);
        s3 = 6'(s2[4:0]) + 6'(s2[5]);
        return (s3 == 6'd0) || (s3 == 6'd31);
    endfunction

    function automatic t_result mk_pay(input logic [7:0] b);
        t_result r;
        r = '0;
        r.result_kind  = KindPayload;
        r.payload_byte = b;
        return r;
    endfunction

    function automatic t_result mk_end(input logic [1:0] st, input logic [1:0] ck,
                                       input logic [31:0] chk, input logic [31:0] sz);
        t_result r;
        r = '0;
        r.result_kind    = KindStatus;
        r.status         = st;
        r.check_kind     = ck;
        r.expected_check = chk;
        r.expected_size  = sz;
        r.final_result   = 1'b1;
        return r;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_hidx  = r_hidx;
        n_flags = r_flags;
        n_xrem  = r_xrem;
        n_crc   = r_crc;
        n_hlow  = r_hlow;
        n_held  = r_held;
        n_dly   = r_dly;
        n_fill  = r_fill;
        n_err   = r_err;
        n_total = (r_total < GzMinBytes) ? r_total + 5'd1 : r_total;
        res_cnt = 2'd0;
        for (int i = 0; i < ResMax; i++) begin
            res[i] = '0;
        end
        skip = 1'b0;
        bad  = 1'b0;
        xlen = '0;
        dep  = GzTrailer;
        ph   = r_phase;

        if (r_phase == PH_START) begin
            if (r_mode == ModeGzip) begin
                ph = PH_GZ_FIXED;
            end else if (r_mode == ModeDeflate) begin
                n_held = i_byte;
                ph     = PH_ZL_SECOND;
                skip   = 1'b1;
            end else begin
                ph = PH_IDENT;
            end
        end
        n_phase = ph;

        if (!skip) begin
            case (ph)
                PH_IDENT, PH_RAW: begin
                    res[res_cnt] = mk_pay(i_byte);
                    res_cnt      = res_cnt + 2'd1;
                end
                PH_GZ_BODY, PH_ZL_BODY: begin
                    dep = (ph == PH_GZ_BODY) ? GzTrailer : ZlTrailer;
                    if (r_fill >= dep) begin
                        // Delay line full: the oldest byte is payload, the rest may be trailer.
                        res[res_cnt] = mk_pay(r_dly[0]);
                        res_cnt      = res_cnt + 2'd1;
                        for (int i = 0; i < 7; i++) begin
                            if (4'(i) < dep - 4'd1) begin
                                n_dly[i] = r_dly[i+1];
                            end
                        end
                        n_dly[3'(dep - 4'd1)] = i_byte;
                    end else begin
                        n_dly[r_fill[2:0]] = i_byte;
                        n_fill             = r_fill + 4'd1;
                    end
                end
                PH_ZL_SECOND: begin
                    if (r_held[3:0] == ZlMethod && r_held[7:4] <= ZlMaxWin && !i_byte[5]
                        && div31({r_held, i_byte})) begin
                        n_phase = PH_ZL_BODY;
                        n_fill  = 4'd0;
                    end else begin
                        res[0]  = mk_pay(r_held);
                        res[1]  = mk_pay(i_byte);
                        res_cnt = 2'd2;
                        n_phase = PH_RAW;
                    end
                end
                PH_GZ_FIXED: begin
                    n_crc = crc_byte(r_crc, i_byte);
                    bad   = (r_hidx == 4'd0 && i_byte != GzMagic0)
                         || (r_hidx == 4'd1 && i_byte != GzMagic1)
                         || (r_hidx == 4'd2 && i_byte != GzMethod)
                         || (r_hidx == 4'd3 && (i_byte & GzFlgRsvd) != 8'd0);
                    if (bad) begin
                        n_err   = StBadHdr;
                        n_phase = PH_DISCARD;
                    end else begin
                        if (r_hidx == 4'd3) begin
                            n_flags = i_byte;
                        end
                        if (r_hidx >= GzFixedEnd) begin
                            n_phase = gz_adv(2'd0, n_flags);
                        end else begin
                            n_hidx = r_hidx + 4'd1;
                        end
                    end
                end
                PH_GZ_XLEN0: begin
                    n_crc   = crc_byte(r_crc, i_byte);
                    n_xrem  = {8'd0, i_byte};
                    n_phase = PH_GZ_XLEN1;
                end
                PH_GZ_XLEN1: begin
                    n_crc   = crc_byte(r_crc, i_byte);
                    xlen    = {i_byte, r_xrem[7:0]};
                    n_xrem  = xlen;
                    n_phase = (xlen == 16'd0) ? gz_adv(2'd1, r_flags) : PH_GZ_EXTRA;
                end
                PH_GZ_EXTRA: begin
                    n_crc  = crc_byte(r_crc, i_byte);
                    n_xrem = r_xrem - 16'd1;
                    if (r_xrem == 16'd1) begin
                        n_phase = gz_adv(2'd1, r_flags);
                    end
                end
                PH_GZ_NAME: begin
                    n_crc = crc_byte(r_crc, i_byte);
                    if (i_byte == 8'd0) begin
                        n_phase = gz_adv(2'd2, r_flags);
                    end
                end
                PH_GZ_COMMENT: begin
                    n_crc = crc_byte(r_crc, i_byte);
                    if (i_byte == 8'd0) begin
                        n_phase = gz_adv(2'd3, r_flags);
                    end
                end
                PH_GZ_HCRC0: begin
                    n_hlow  = i_byte;
                    n_phase = PH_GZ_HCRC1;
                end
                PH_GZ_HCRC1: begin
                    if ({i_byte, r_hlow} != ~r_crc[15:0]) begin
                        n_err   = StHcrc;
                        n_phase = PH_DISCARD;
                    end else begin
                        n_phase = PH_GZ_BODY;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_last) begin
            if (n_phase == PH_ZL_SECOND) begin
                // A lone first byte cannot be a zlib header, so it is raw deflate.
                res[res_cnt] = mk_pay(n_held);
                res_cnt      = res_cnt + 2'd1;
                res[res_cnt] = mk_end(StOk, CkNone, 32'd0, 32'd0);
                res_cnt      = res_cnt + 2'd1;
            end else if (n_phase == PH_ZL_BODY) begin
                if (n_fill < ZlTrailer) begin
                    res[res_cnt] = mk_end(StTrunc, CkNone, 32'd0, 32'd0);
                end else begin
                    res[res_cnt] = mk_end(StOk, CkAdler,
                                          {n_dly[0], n_dly[1], n_dly[2], n_dly[3]}, 32'd0);
                end
                res_cnt = res_cnt + 2'd1;
            end else if (n_phase == PH_IDENT || n_phase == PH_RAW) begin
                res[res_cnt] = mk_end(StOk, CkNone, 32'd0, 32'd0);
                res_cnt      = res_cnt + 2'd1;
            end else begin
                if (n_total < GzMinBytes || (n_err == StOk
                    && !(n_phase == PH_GZ_BODY && n_fill >= GzTrailer))) begin
                    res[res_cnt] = mk_end(StTrunc, CkNone, 32'd0, 32'd0);
                end else if (n_err != StOk) begin
                    res[res_cnt] = mk_end(n_err, CkNone, 32'd0, 32'd0);
                end else begin
                    res[res_cnt] = mk_end(StOk, CkCrc32,
                                          {n_dly[3], n_dly[2], n_dly[1], n_dly[0]},
                                          {n_dly[7], n_dly[6], n_dly[5], n_dly[4]});
                end
                res_cnt = res_cnt + 2'd1;
            end
            // The next body starts from a clean parser.
            n_phase = PH_START;
            n_hidx  = '0;
            n_flags = '0;
            n_xrem  = '0;
            n_crc   = CrcInit;
            n_hlow  = '0;
            n_held  = '0;
            n_fill  = '0;
            n_total = '0;
            n_err   = StOk;
        end

        // Results reach the queue only for an item that is actually parsed.
        o_push.cnt = i_fire ? res_cnt : 2'd0;
        for (int i = 0; i < ResMax; i++) begin
            o_push.res[i] = res[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            if (!i_rst_n) begin
                r_mode <= ModeGzip;
            end else begin
                r_mode <= i_cfg_wdata;
            end
            r_phase <= PH_START;
            r_hidx  <= '0;
            r_flags <= '0;
            r_xrem  <= '0;
            r_crc   <= CrcInit;
            r_hlow  <= '0;
            r_held  <= '0;
            r_fill  <= '0;
            r_total <= '0;
            r_err   <= StOk;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_flags <= n_flags;
            r_xrem  <= n_xrem;
            r_crc   <= n_crc;
            r_hlow  <= n_hlow;
            r_held  <= n_held;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_dly <= n_dly;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |=> r_phase == PH_START)
        else $error("parser did not restart after the last item of a body");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |-> o_push.cnt != 2'd0
            && o_push.res[o_push.cnt - 2'd1].final_result)
        else $error("last item of a body gave no end status");
`endif

endmodule

FILE: rtl/gzd_res_fifo.sv
module gzd_res_fifo
    import gzd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_head,
    output logic    o_room
);

    t_result    r_mem [FifoDepth];
    logic [1:0] r_wptr;
    logic [1:0] r_rptr;
    logic [2:0] r_count;
    logic [2:0] after_pop;

    assign o_valid   = (r_count != 3'd0);
    assign o_head    = r_mem[r_rptr];
    assign after_pop = r_count - {2'd0, i_pop};
    // Room for the worst case of one item: three results.
    assign o_room    = (after_pop <= 3'(FifoDepth - ResMax));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ResMax; k++) begin
            if (2'(k) < i_push.cnt) begin
                r_mem[r_wptr + 2'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + i_push.cnt;
            r_rptr  <= r_rptr + {1'b0, i_pop};
            r_count <= after_pop + {1'b0, i_push.cnt};
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, after_pop} + {2'b0, i_push.cnt}) <= 4'(FifoDepth))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 3'd0)
        else $error("result queue popped while empty");
`endif

endmodule

FILE: rtl/gzip_zlib_container_deframer.sv
// Timing: an item is registered at acceptance and parsed once the result queue has room;
// its results are then written into the queue and offered from the queue head.
// Throughput: one item per cycle while items yield at most one result each and the
// receiver takes each result; the four-entry result queue must have room for three results before an item is parsed.
// Reset (i_rst_n, synchronous, active low) selects gzip mode and restarts the parser;
// a configuration write restarts it as well.
module gzip_zlib_container_deframer
    import gzd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    gzd_in_if.sink     i_in,
    gzd_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       fire;
    logic       room;
    logic       pop;
    t_push      push;
    t_result    head;

    assign fire       = r_in_vld && room;
    assign i_in.ready = !r_in_vld || fire;
    assign pop        = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    gzd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_push      (push)
    );

    gzd_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (o_out.valid),
        .o_head  (head),
        .o_room  (room)
    );

    assign o_out.result_kind    = head.result_kind;
    assign o_out.payload_byte   = head.payload_byte;
    assign o_out.status         = head.status;
    assign o_out.check_kind     = head.check_kind;
    assign o_out.expected_check = head.expected_check;
    assign o_out.expected_size  = head.expected_size;
    assign o_out.final_result   = head.final_result;

endmodule

FILE: tb/sv/gzd_result_checker.sv
`timescale 1ns / 100ps

module gzd_result_checker
    import gzd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    gzd_in_if          i_in,
    gzd_out_if         i_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    localparam int ZlCheckBase = 31;
    localparam int PrintCap    = 20;

    // Shadow copy of the parser state.
    logic [1:0]  mode;
    t_phase      phase;
    logic [3:0]  hdr_idx;
    logic [7:0]  flags;
    logic [15:0] xlen_left;
    logic [31:0] hdr_crc;
    logic [7:0]  hcrc_lo;
    logic [7:0]  first_byte;
    logic [7:0]  trail [8];
    logic [3:0]  fill;
    logic [4:0]  seen;
    logic [1:0]  err;

    t_result results_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_fail(input string msg);
        o_fail_count++;
        if (o_fail_count <= PrintCap) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic restart_parser();
        phase      = PH_START;
        hdr_idx    = '0;
        flags      = '0;
        xlen_left  = '0;
        hdr_crc    = CrcInit;
        hcrc_lo    = '0;
        first_byte = '0;
        fill       = '0;
        seen       = '0;
        err        = StOk;
        for (int k = 0; k < 8; k++) begin
            trail[k] = '0;
        end
    endtask

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
        end
        return r;
    endfunction

    // Next gzip header field after the one given by level:
    // 0 fixed part, 1 extra, 2 name, 3 comment.
    function automatic t_phase next_gz(input int level);
        if (level < 1 && flags[2]) return PH_GZ_XLEN0;
        if (level < 2 && flags[3]) return PH_GZ_NAME;
        if (level < 3 && flags[4]) return PH_GZ_COMMENT;
        if (flags[1]) return PH_GZ_HCRC0;
        return PH_GZ_BODY;
    endfunction

    task automatic due_payload(input logic [7:0] b);
        t_result r;
        r = '0;
        r.result_kind  = KindPayload;
        r.payload_byte = b;
        results_due.push_back(r);
    endtask

    task automatic due_status(input logic [1:0] st, input logic [1:0] ck,
                              input logic [31:0] chk, input logic [31:0] sz);
        t_result r;
        r = '0;
        r.result_kind    = KindStatus;
        r.status         = st;
        r.check_kind     = ck;
        r.expected_check = chk;
        r.expected_size  = sz;
        r.final_result   = 1'b1;
        results_due.push_back(r);
    endtask

    // The trailer is held back: a byte leaves only once depth newer ones follow it.
    task automatic shift_trailer(input logic [7:0] b, input int depth);
        if (fill >= depth) begin
            due_payload(trail[0]);
            for (int k = 0; k < depth - 1; k++) begin
                trail[k] = trail[k + 1];
            end
            trail[depth - 1] = b;
        end else begin
            trail[fill[2:0]] = b;
            fill++;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic last);
        logic        held_only;
        logic [15:0] zl_hdr;
        held_only = 1'b0;
        if (seen < GzMinBytes) seen++;

        if (phase == PH_START) begin
            if (mode == ModeGzip) begin
                phase   = PH_GZ_FIXED;
                hdr_idx = '0;
            end else if (mode == ModeDeflate) begin
                // The first byte waits until the second says whether it is zlib.
                first_byte = b;
                phase      = PH_ZL_SECOND;
                held_only  = 1'b1;
            end else begin
                phase = PH_IDENT;
            end
        end

        if (!held_only) begin
            case (phase)
                PH_IDENT, PH_RAW: begin
                    due_payload(b);
                end
                PH_GZ_BODY: begin
                    shift_trailer(b, GzTrailer);
                end
                PH_ZL_BODY: begin
                    shift_trailer(b, ZlTrailer);
                end
                PH_ZL_SECOND: begin
                    zl_hdr = {first_byte, b};
                    if (first_byte[3:0] == ZlMethod && first_byte[7:4] <= ZlMaxWin &&
                        !b[5] && (zl_hdr % ZlCheckBase) == 0) begin
                        phase = PH_ZL_BODY;
                        fill  = '0;
                    end else begin
                        due_payload(first_byte);
                        due_payload(b);
                        phase = PH_RAW;
                    end
                end
                PH_GZ_FIXED: begin
                    hdr_crc = crc_step(hdr_crc, b);
                    if ((hdr_idx == 0 && b != GzMagic0) || (hdr_idx == 1 && b != GzMagic1) ||
                        (hdr_idx == 2 && b != GzMethod) ||
                        (hdr_idx == 3 && (b & GzFlgRsvd) != 0)) begin
                        err   = StBadHdr;
                        phase = PH_DISCARD;
                    end else begin
                        if (hdr_idx == 3) flags = b;
                        if (hdr_idx >= GzFixedEnd) phase = next_gz(0);
                        else hdr_idx++;
                    end
                end
                PH_GZ_XLEN0: begin
                    hdr_crc   = crc_step(hdr_crc, b);
                    xlen_left = {8'd0, b};
                    phase     = PH_GZ_XLEN1;
                end
                PH_GZ_XLEN1: begin
                    hdr_crc         = crc_step(hdr_crc, b);
                    xlen_left[15:8] = b;
                    phase           = (xlen_left == 0) ? next_gz(1) : PH_GZ_EXTRA;
                end
                PH_GZ_EXTRA: begin
                    hdr_crc = crc_step(hdr_crc, b);
                    xlen_left--;
                    if (xlen_left == 0) phase = next_gz(1);
                end
                PH_GZ_NAME: begin
                    hdr_crc = crc_step(hdr_crc, b);
                    if (b == 0) phase = next_gz(2);
                end
                PH_GZ_COMMENT: begin
                    hdr_crc = crc_step(hdr_crc, b);
                    if (b == 0) phase = next_gz(3);
                end
                PH_GZ_HCRC0: begin
                    hcrc_lo = b;
                    phase   = PH_GZ_HCRC1;
                end
                PH_GZ_HCRC1: begin
                    if ({b, hcrc_lo} != ~hdr_crc[15:0]) begin
                        err   = StHcrc;
                        phase = PH_DISCARD;
                    end else begin
                        phase = PH_GZ_BODY;
                    end
                end
                default: begin
                end
            endcase
        end

        if (last) begin
            case (phase)
                PH_ZL_SECOND: begin
                    due_payload(first_byte);
                    due_status(StOk, CkNone, '0, '0);
                end
                PH_ZL_BODY: begin
                    if (fill < ZlTrailer) due_status(StTrunc, CkNone, '0, '0);
                    else due_status(StOk, CkAdler,
                                    {trail[0], trail[1], trail[2], trail[3]}, '0);
                end
                PH_IDENT, PH_RAW: begin
                    due_status(StOk, CkNone, '0, '0);
                end
                default: begin
                    // A short body is reported as truncated even over a header error.
                    if (seen < GzMinBytes ||
                        (err == StOk && !(phase == PH_GZ_BODY && fill >= GzTrailer))) begin
                        due_status(StTrunc, CkNone, '0, '0);
                    end else if (err != StOk) begin
                        due_status(err, CkNone, '0, '0);
                    end else begin
                        due_status(StOk, CkCrc32,
                                   {trail[3], trail[2], trail[1], trail[0]},
                                   {trail[7], trail[6], trail[5], trail[4]});
                    end
                end
            endcase
            restart_parser();
        end
    endtask

    task automatic compare_result();
        t_result want;
        if (results_due.size() == 0) begin
            report_fail($sformatf("result with nothing expected: kind %0d byte %02h status %0d",
                                  i_out.result_kind, i_out.payload_byte, i_out.status));
        end else begin
            want = results_due.pop_front();
            if (i_out.result_kind !== want.result_kind)
                report_fail($sformatf("result %0d: result_kind %0h, expected %0h",
                                      o_checked, i_out.result_kind, want.result_kind));
            if (i_out.payload_byte !== want.payload_byte)
                report_fail($sformatf("result %0d: payload_byte %0h, expected %0h",
                                      o_checked, i_out.payload_byte, want.payload_byte));
            if (i_out.status !== want.status)
                report_fail($sformatf("result %0d: status %0h, expected %0h",
                                      o_checked, i_out.status, want.status));
            if (i_out.check_kind !== want.check_kind)
                report_fail($sformatf("result %0d: check_kind %0h, expected %0h",
                                      o_checked, i_out.check_kind, want.check_kind));
            if (i_out.expected_check !== want.expected_check)
                report_fail($sformatf("result %0d: expected_check %0h, expected %0h",
                                      o_checked, i_out.expected_check, want.expected_check));
            if (i_out.expected_size !== want.expected_size)
                report_fail($sformatf("result %0d: expected_size %0h, expected %0h",
                                      o_checked, i_out.expected_size, want.expected_size));
            if (i_out.final_result !== want.final_result)
                report_fail($sformatf("result %0d: final_result %0h, expected %0h",
                                      o_checked, i_out.final_result, want.final_result));
        end
        o_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode = ModeGzip;
            restart_parser();
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                mode = i_cfg_wdata;
                restart_parser();
            end
            // Results are matched before this edge's item is predicted, since an
            // item's own results can never leave in the cycle it is taken.
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) compare_result();
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                deframe_byte(i_in.data_byte, i_in.last_byte);
            end
        end
        o_pending = results_due.size();
    end

endmodule

FILE: tb/sv/gzip_zlib_container_deframer_test.sv
`timescale 1ns / 100ps

module gzip_zlib_container_deframer_test;
    import gzd_pkg::*;

    // The register is two bits wide; the unused code must act as identity.
    localparam logic [1:0] ModeSpare = 2'd3;

    localparam int IdlePct     = 8;
    localparam int RandomItems = 300;
    localparam int StallLimit  = 2000;
    localparam int HoldCycles  = 80;
    localparam int DrainCycles = 8;
    localparam int ZlCheckBase = 31;

    // Smallest legal gzip body: fixed header, no options, empty payload, trailer.
    localparam logic [143:0] MinGzip = {GzMagic0, GzMagic1, GzMethod, 8'h00,
                                        32'h00FF00FF, 8'hFF, 8'h00,
                                        64'h00FF807F_FF0001FE};

    typedef enum int {
        GzGood, GzBadMagic0, GzBadMagic1, GzBadMethod,
        GzRsvdFlag, GzBadHcrc, GzCutHeader, GzCutTrailer
    } t_gz_variant;

    typedef enum int {
        ZlGood, ZlDict, ZlBadCheck, ZlBadMethod,
        ZlShortTrailer, ZlHeaderOnly, ZlOneByte, ZlRaw
    } t_zl_variant;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_wdata = 2'd0;

    gzd_in_if  in_ch ();
    gzd_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;

    int         items_sent  = 0;
    int         n_ident     = 0;
    int         n_gzip      = 0;
    int         n_deflate   = 0;
    int         idle_cycles = 0;
    bit         quiet       = 1'b0;
    bit         want_hold   = 1'b0;
    logic [1:0] cur_mode    = ModeGzip;
    logic [7:0] body_q [$];

    always #5 i_clk = ~i_clk;

    gzip_zlib_container_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    gzd_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Receiver: random back-pressure, plus one long hold-off so the block backs up.
    initial begin
        bit hold_done;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (want_hold && !hold_done) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                out_ch.ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit) begin
            $display("Watchdog: no item moved for %0d cycles", StallLimit);
            $display("FAIL gzip_zlib_container_deframer");
            $finish;
        end
    end

    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
        end
        return r;
    endfunction

    // Valid is left high after an item so that the next one can follow back to back.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!quiet && $urandom_range(0, 99) < IdlePct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        quiet = (items_sent >= 150) && (items_sent < 230);
        if (items_sent == 100) want_hold = 1'b1;
    endtask

    task automatic send_body();
        for (int k = 0; k < body_q.size(); k++) begin
            send_byte(body_q[k], k == body_q.size() - 1);
        end
        if (cur_mode == ModeGzip) n_gzip++;
        else if (cur_mode == ModeDeflate) n_deflate++;
        else n_ident++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        in_ch.valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = m;
    endtask

    task automatic push_zstring();
        repeat ($urandom_range(0, 4)) body_q.push_back(8'($urandom_range(1, 255)));
        body_q.push_back(8'h00);
    endtask

    task automatic build_gzip(input t_gz_variant variant);
        logic [7:0]  flg;
        logic [15:0] xlen;
        logic [15:0] hc;
        logic [31:0] crc;
        int          hdr_len;
        int          keep;
        body_q.delete();
        flg = 8'($urandom_range(0, 31));
        if (variant == GzBadHcrc) flg[1] = 1'b1;
        body_q.push_back(variant == GzBadMagic0 ?
                         GzMagic0 ^ 8'(8'h01 << $urandom_range(0, 7)) : GzMagic0);
        body_q.push_back(variant == GzBadMagic1 ?
                         GzMagic1 ^ 8'(8'h01 << $urandom_range(0, 7)) : GzMagic1);
        body_q.push_back(variant == GzBadMethod ?
                         GzMethod ^ 8'(8'h01 << $urandom_range(0, 7)) : GzMethod);
        body_q.push_back(variant == GzRsvdFlag ?
                         flg | 8'(8'h20 << $urandom_range(0, 2)) : flg);
        repeat (6) body_q.push_back(8'($urandom));
        if (flg[2]) begin
            // Mostly short extra fields; now and then one past 255 bytes.
            xlen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(256, 300))
                                               : 16'($urandom_range(0, 4));
            body_q.push_back(xlen[7:0]);
            body_q.push_back(xlen[15:8]);
            repeat (xlen) body_q.push_back(8'($urandom));
        end
        if (flg[3]) push_zstring();
        if (flg[4]) push_zstring();
        if (flg[1]) begin
            crc = CrcInit;
            foreach (body_q[k]) crc = crc32_byte(crc, body_q[k]);
            hc = ~crc[15:0];
            if (variant == GzBadHcrc) hc = hc ^ 16'(16'h0001 << $urandom_range(0, 15));
            body_q.push_back(hc[7:0]);
            body_q.push_back(hc[15:8]);
        end
        hdr_len = body_q.size();
        repeat ($urandom_range(0, 10)) body_q.push_back(8'($urandom));
        repeat (8) body_q.push_back(8'($urandom));
        if (variant == GzCutHeader) begin
            keep = $urandom_range(1, hdr_len);
            while (body_q.size() > keep) void'(body_q.pop_back());
        end else if (variant == GzCutTrailer) begin
            repeat ($urandom_range(1, 8)) void'(body_q.pop_back());
        end
    endtask

    task automatic build_zlib(input t_zl_variant variant);
        logic [7:0]  cmf;
        logic [7:0]  flg;
        logic [15:0] hdr;
        body_q.delete();
        cmf = {4'($urandom_range(0, 7)), ZlMethod};
        if (variant == ZlBadMethod) begin
            if ($urandom_range(0, 1) == 1) cmf[7:4] = 4'($urandom_range(8, 15));
            else cmf[3:0] = ZlMethod ^ 4'($urandom_range(1, 15));
        end
        flg = {2'($urandom_range(0, 3)), variant == ZlDict, 5'd0};
        hdr = {cmf, flg};
        flg[4:0] = 5'((ZlCheckBase - (hdr % ZlCheckBase)) % ZlCheckBase);
        // A flip of one check bit moves the header off a multiple of 31.
        if (variant == ZlBadCheck) flg[4:0] = flg[4:0] ^ 5'(5'd1 << $urandom_range(0, 4));
        case (variant)
            ZlOneByte: begin
                body_q.push_back(8'($urandom));
            end
            ZlRaw: begin
                repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom));
            end
            default: begin
                body_q.push_back(cmf);
                body_q.push_back(flg);
                if (variant == ZlShortTrailer) begin
                    repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom));
                end else if (variant != ZlHeaderOnly) begin
                    repeat ($urandom_range(4, 14)) body_q.push_back(8'($urandom));
                end
            end
        endcase
    endtask

    initial begin
        int r;
        int base_items;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting in the reset mode (gzip).
        body_q.delete();
        for (int k = 17; k >= 0; k--) body_q.push_back(MinGzip[k * 8 +: 8]);
        send_body();
        body_q = {8'h00};
        send_body();
        write_mode(ModeSpare);
        body_q = {8'hFF};
        send_body();
        write_mode(ModeIdentity);
        body_q = {8'h00};
        send_body();
        write_mode(ModeDeflate);
        body_q = {8'h78};
        send_body();
        body_q = {8'h78, 8'h9C};
        send_body();
        base_items = items_sent;

        // Random part: a mode per session, mostly well-formed bodies.
        while (items_sent < base_items + RandomItems) begin
            r = $urandom_range(0, 9);
            write_mode(r == 0 ? ModeIdentity : r == 1 ? ModeSpare :
                       r <= 5 ? ModeGzip : ModeDeflate);
            repeat ($urandom_range(1, 4)) begin
                if (cur_mode == ModeGzip) begin
                    r = $urandom_range(0, 18);
                    build_gzip(r < 12 ? GzGood : t_gz_variant'(r - 11));
                end else if (cur_mode == ModeDeflate) begin
                    r = $urandom_range(0, 13);
                    build_zlib(r < 6 ? ZlGood : t_zl_variant'(r - 6));
                end else begin
                    body_q.delete();
                    repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom));
                end
                send_body();
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        $display("Covered %0d items in %0d bodies (%0d identity, %0d gzip, %0d deflate).",
                 items_sent, n_ident + n_gzip + n_deflate, n_ident, n_gzip, n_deflate);
        $display("Checked %0d results, with one output hold-off of %0d cycles; %0d errors.",
                 checked, HoldCycles, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS gzip_zlib_container_deframer");
        end else begin
            $display("FAIL gzip_zlib_container_deframer");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/gzd_pkg.sv
rtl/gzd_if.sv
rtl/gzd_parser.sv
rtl/gzd_res_fifo.sv
rtl/gzip_zlib_container_deframer.sv
tb/sv/gzd_result_checker.sv
tb/sv/gzip_zlib_container_deframer_test.sv
